// ===== rtl/rde_pkg.sv =====
// Shared constants, types and the digit-to-ASCII function for the radix digit emitter.
`timescale 1ns / 1ps

package rde_pkg;

  // Field widths.
  localparam int VALUE_W = 64;
  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;

  // Digit store sizing.
  localparam int MAX_DIGITS = 64;
  localparam int ADDR_W     = $clog2(MAX_DIGITS);
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

  // Serial divider bit counter.
  localparam int BIT_CNT_W = $clog2(VALUE_W);

  // Base limits and character mapping.
  localparam logic [RADIX_W-1:0] RADIX_MIN     = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX     = RADIX_W'(36);
  localparam logic [7:0]         LETTER_OFFSET = 8'd87;
  localparam logic [7:0]         ZERO_CHAR     = 8'd48;
  localparam logic [DIGIT_W-1:0] LAST_DECIMAL  = DIGIT_W'(9);

  // Control sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_READ,
    S_LOAD
  } rde_state_e;

  // Report from the serial divider, one per finished digit.
  typedef struct packed {
    logic               digit_valid;
    logic               final_digit;
    logic [DIGIT_W-1:0] digit;
  } rde_div_status_t;

  // Map a digit value onto its ASCII character.
  function automatic logic [CHAR_W-1:0] glyph_of(input logic [DIGIT_W-1:0] d);
    logic [7:0] c;
    if (d <= LAST_DECIMAL) begin
      c = 8'(d) + ZERO_CHAR;
    end else begin
      c = 8'(d) + LETTER_OFFSET;
    end
    return c[CHAR_W-1:0];
  endfunction

endpackage

// ===== rtl/rde_serial_div.sv =====
// Bit-serial restoring divider that splits a 64-bit value into digits of a small base.
`timescale 1ns / 1ps

module rde_serial_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rde_pkg::VALUE_W-1:0]   value_i,
  input  logic [rde_pkg::RADIX_W-1:0]   radix_i,
  output rde_pkg::rde_div_status_t      status_o
);
  import rde_pkg::*;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(VALUE_W - 1);

  logic                 running_q, running_d;
  logic [BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [VALUE_W-1:0]   res_q, res_d;
  logic [DIGIT_W-1:0]   rem_q, rem_d;
  logic [DIGIT_W-1:0]   base_q, base_d;
  logic                 qnz_q, qnz_d;

  logic [DIGIT_W:0]     trial;
  logic [DIGIT_W:0]     diff;
  logic                 qbit;
  logic [DIGIT_W-1:0]   rem_next;
  logic                 last_bit;
  logic [DIGIT_W-1:0]   base_clamped;

  // Clamp the requested base into the supported range.
  always_comb begin
    if (radix_i < RADIX_MIN) begin
      base_clamped = DIGIT_W'(RADIX_MIN);
    end else if (radix_i > RADIX_MAX) begin
      base_clamped = DIGIT_W'(RADIX_MAX);
    end else begin
      base_clamped = DIGIT_W'(radix_i);
    end
  end

  // One restoring division step: bring down the next dividend bit and try a subtract.
  assign trial    = {rem_q, res_q[VALUE_W-1]};
  assign diff     = trial - {1'b0, base_q};
  assign qbit     = (trial >= {1'b0, base_q});
  assign rem_next = qbit ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
  assign last_bit = running_q && (bit_cnt_q == LAST_BIT);

  // The quotient replaces the dividend bit by bit, so the residue register holds
  // the next dividend once a digit is finished.
  always_comb begin
    running_d = running_q;
    bit_cnt_d = bit_cnt_q;
    res_d     = res_q;
    rem_d     = rem_q;
    base_d    = base_q;
    qnz_d     = qnz_q;
    if (start_i) begin
      running_d = 1'b1;
      bit_cnt_d = '0;
      res_d     = value_i;
      rem_d     = '0;
      base_d    = base_clamped;
      qnz_d     = 1'b0;
    end else if (running_q) begin
      res_d     = {res_q[VALUE_W-2:0], qbit};
      rem_d     = rem_next;
      qnz_d     = qnz_q | qbit;
      bit_cnt_d = bit_cnt_q + BIT_CNT_W'(1);
      if (last_bit) begin
        // Start over on the quotient, or stop when it is zero.
        rem_d     = '0;
        qnz_d     = 1'b0;
        bit_cnt_d = '0;
        running_d = qnz_q | qbit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      bit_cnt_q <= '0;
      qnz_q     <= 1'b0;
      res_q     <= '0;
    end else begin
      running_q <= running_d;
      bit_cnt_q <= bit_cnt_d;
      qnz_q     <= qnz_d;
      res_q     <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    base_q <= base_d;
  end

  // Report the finished digit on the last step of each pass.
  assign status_o.digit_valid = last_bit;
  assign status_o.final_digit = !(qnz_q | qbit);
  assign status_o.digit       = rem_next;

endmodule

// ===== rtl/radix_digit_emitter.sv =====
// Top level of the radix digit emitter: serial divider, digit store and output stage.
`timescale 1ns / 1ps

// Converts an unsigned 64-bit value into ASCII digits of a base from 2 to 36.
// Input channel: value_i and radix_i with in_valid_i; the block stalls the
// channel with in_stall_o while a conversion is in progress. A radix below 2
// is used as 2 and one above 36 as 36.
// Output channel: one request per digit on digit_char_o and last_o with
// out_valid_o, most significant digit first; last_o marks the final digit.
// A zero value gives the single digit '0'.
// Operation: the bit-serial divider produces each digit one dividend bit per
// cycle. Each digit is then read from the digit store in S_READ and loaded
// into the output register in S_LOAD, which waits while the receiver stalls.
// A stall on the output holds the current digit and pauses the read-out. The
// next input request is taken once the last digit is in the output register.
// Reset clears the sequencer, the divider and the output valid flag.

module radix_digit_emitter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rde_pkg::VALUE_W-1:0]  value_i,
  input  logic [rde_pkg::RADIX_W-1:0]  radix_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rde_pkg::CHAR_W-1:0]   digit_char_o,
  output logic                         last_o
);
  import rde_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  rde_state_e         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  digit_char_q, digit_char_d;
  logic               last_q, last_d;
  logic [DIGIT_W-1:0] rd_data_q;

  logic [DIGIT_W-1:0] store_mem [MAX_DIGITS];
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [CNT_W-1:0]   cnt_dec;
  logic [ADDR_W-1:0]  rd_addr;

  logic               in_accept;
  logic               out_free;
  rde_div_status_t    div_status;

  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign cnt_dec   = cnt_q - CNT_ONE;
  assign rd_addr   = cnt_dec[ADDR_W-1:0];
  assign wr_addr   = cnt_q[ADDR_W-1:0];

  // Serial divider produces digits least significant first.
  rde_serial_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_accept),
    .value_i  (value_i),
    .radix_i  (radix_i),
    .status_o (div_status)
  );

  // Sequencer: collect digits, then read them back in reverse order.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    wr_en        = 1'b0;
    digit_char_d = digit_char_q;
    last_d       = last_q;
    out_valid_d  = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cnt_d   = '0;
          state_d = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (div_status.digit_valid) begin
          // Once the store is full, further digits are dropped.
          if (cnt_q < CNT_MAX) begin
            wr_en = 1'b1;
            cnt_d = cnt_q + CNT_ONE;
          end
          if (div_status.final_digit) begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          digit_char_d = glyph_of(rd_data_q);
          last_d       = (cnt_q == CNT_ONE);
          cnt_d        = cnt_dec;
          state_d      = (cnt_q == CNT_ONE) ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    digit_char_q <= digit_char_d;
    last_q       <= last_d;
  end

  // Digit store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= div_status.digit;
    end
    if (state_q == S_READ) begin
      rd_data_q <= store_mem[rd_addr];
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign digit_char_o = digit_char_q;
  assign last_o       = last_q;

  // The divider only reports digits while the sequencer collects them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_status.digit_valid |-> state_q == S_DIVIDE)
    else $error("divider reported a digit outside the divide phase");

  // A read-out never starts with an empty store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ || state_q == S_LOAD) |-> cnt_q != '0)
    else $error("digit read-out with no digits held");

  // The digit count never exceeds the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("digit count beyond store depth");

  // A new output request only comes from the load step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_LOAD)
    else $error("output valid rose outside the load step");

endmodule
